/* src/fca_pkg.sv */
// ----------------------------------------------------------------------------
// fca_pkg
// Types and constants shared by the block allocation table chain allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fca_pkg;

  localparam int unsigned NumBlocks = 1024;

  localparam logic [15:0] LinkFree = 16'hFFFF;
  localparam logic [15:0] LinkEnd  = 16'hFFFE;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_END,
    S_FREE_WALK,
    S_READ_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    req_e        req_type;
    logic [10:0] block_count;
    logic [9:0]  block_index;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [9:0]  block_addr;
    logic        is_end;
    logic [10:0] free_count;
  } rsp_t;

endpackage

`default_nettype wire

/* src/fca_if.sv */
// ----------------------------------------------------------------------------
// fca_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface fca_req_if;
  logic          valid;
  logic          ready;
  fca_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fca_rsp_if;
  logic          valid;
  logic          ready;
  fca_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/fat_chain_allocator.sv */
// ----------------------------------------------------------------------------
// fat_chain_allocator
// Block allocation table that builds, walks and frees chains of block links.
// ----------------------------------------------------------------------------
// Requests arrive on req_i and one response per request leaves on rsp_o,
// both valid/ready; a transaction moves on a clock edge with valid and ready
// high. One request is in work at a time; req_i.ready is high in idle only.
// Work from accept to response ready (link table is one RAM port pair):
//   allocate : one table entry scanned per cycle until the chain is built
//   free     : one chain link walked per cycle, plus a read that finds
//              the free entry when the walk stops at a link to a free block
//   read link: one table read, rejected requests: no table access,
//   free of a free block: one table read; clear all: one entry written per cycle
// After reset a clearing pass writes every entry free, and no request is
// accepted during the pass. The response is held in an output
// register; a new request is accepted while it waits, and a finished result
// waits in the sequencer until the receiver takes the previous one.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_chain_allocator #(
  parameter int unsigned NUM_BLOCKS = fca_pkg::NumBlocks
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fca_req_if.sink   req_i,
  fca_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned FW = $clog2(NUM_BLOCKS + 1);

  fca_pkg::state_e state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            clr_resp_q, clr_resp_d;
  logic [AW-1:0]   scan_q, scan_d;
  logic [AW-1:0]   cur_q, cur_d;
  logic [AW-1:0]   prev_q, prev_d;
  logic [AW-1:0]   first_q, first_d;
  logic            pend_q, pend_d;
  logic            head_q, head_d;
  logic [10:0]     taken_q, taken_d;
  logic [10:0]     count_q, count_d;
  logic [FW-1:0]   free_q, free_d;

  fca_pkg::status_e res_status_q, res_status_d;
  logic [9:0]       res_addr_q, res_addr_d;
  logic             res_end_q, res_end_d;

  logic          out_valid_q, out_valid_d;
  fca_pkg::rsp_t out_data_q, out_data_d;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;

  logic [AW+9:0] first_ext;
  logic [FW+10:0] free_ext;
  logic          idx_ok;

  assign first_ext = {10'b0, first_q};
  assign free_ext  = {11'b0, free_q};
  assign idx_ok    = 32'(req_i.data.block_index) < NUM_BLOCKS;

  assign req_i.ready = (state_q == fca_pkg::S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  fca_ram #(
    .WIDTH(16),
    .DEPTH(NUM_BLOCKS)
  ) u_link_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    clr_resp_d   = clr_resp_q;
    scan_d       = scan_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    first_d      = first_q;
    pend_d       = pend_q;
    head_d       = head_q;
    taken_d      = taken_q;
    count_d      = count_q;
    free_d       = free_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_end_d    = res_end_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    wr_en        = 1'b0;
    wr_addr      = cur_q;
    wr_data      = fca_pkg::LinkFree;
    rd_en        = 1'b0;
    rd_addr      = AW'(req_i.data.block_index);

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      fca_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = fca_pkg::LinkFree;
        clr_d   = clr_q + 1'b1;
        if (32'(clr_q) == NUM_BLOCKS - 1) begin
          free_d     = FW'(NUM_BLOCKS);
          clr_resp_d = 1'b0;
          if (clr_resp_q) begin
            res_status_d = fca_pkg::ST_OK;
            res_addr_d   = '0;
            res_end_d    = 1'b0;
            state_d      = fca_pkg::S_DONE;
          end else begin
            state_d = fca_pkg::S_IDLE;
          end
        end
      end

      fca_pkg::S_IDLE: begin
        res_status_d = fca_pkg::ST_OK;
        res_addr_d   = '0;
        res_end_d    = 1'b0;
        cur_d        = AW'(req_i.data.block_index);
        if (req_i.valid) begin
          case (req_i.data.req_type)
            fca_pkg::REQ_ALLOC: begin
              if (req_i.data.block_count == '0) begin
                res_status_d = fca_pkg::ST_INVALID;
                state_d      = fca_pkg::S_DONE;
              end else if (32'(req_i.data.block_count) > 32'(free_q)) begin
                res_status_d = fca_pkg::ST_NOSPACE;
                state_d      = fca_pkg::S_DONE;
              end else begin
                count_d = req_i.data.block_count;
                taken_d = '0;
                scan_d  = '0;
                pend_d  = 1'b0;
                state_d = fca_pkg::S_ALLOC_SCAN;
              end
            end
            fca_pkg::REQ_FREE: begin
              if (!idx_ok) begin
                res_status_d = fca_pkg::ST_INVALID;
                state_d      = fca_pkg::S_DONE;
              end else begin
                rd_en   = 1'b1;
                head_d  = 1'b1;
                state_d = fca_pkg::S_FREE_WALK;
              end
            end
            fca_pkg::REQ_READ: begin
              if (!idx_ok) begin
                res_status_d = fca_pkg::ST_INVALID;
                state_d      = fca_pkg::S_DONE;
              end else begin
                rd_en   = 1'b1;
                state_d = fca_pkg::S_READ_WAIT;
              end
            end
            default: begin
              clr_d      = '0;
              clr_resp_d = 1'b1;
              state_d    = fca_pkg::S_CLEAR;
            end
          endcase
        end
      end

      fca_pkg::S_ALLOC_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_q;
        scan_d  = scan_q + 1'b1;
        cur_d   = scan_q;
        pend_d  = 1'b1;
        if (pend_q && rd_data == fca_pkg::LinkFree) begin
          if (taken_q == '0) begin
            first_d = cur_q;
          end else begin
            wr_en   = 1'b1;
            wr_addr = prev_q;
            wr_data = 16'(cur_q);
          end
          prev_d  = cur_q;
          taken_d = taken_q + 1'b1;
          if (taken_q + 11'd1 == count_q) begin
            state_d = fca_pkg::S_ALLOC_END;
          end
        end
      end

      fca_pkg::S_ALLOC_END: begin
        wr_en        = 1'b1;
        wr_addr      = prev_q;
        wr_data      = fca_pkg::LinkEnd;
        free_d       = FW'(32'(free_q) - 32'(count_q));
        res_status_d = fca_pkg::ST_OK;
        res_addr_d   = first_ext[9:0];
        state_d      = fca_pkg::S_DONE;
      end

      fca_pkg::S_FREE_WALK: begin
        if (rd_data == fca_pkg::LinkFree) begin
          res_status_d = head_q ? fca_pkg::ST_INVALID : fca_pkg::ST_OK;
          state_d      = fca_pkg::S_DONE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = cur_q;
          wr_data = fca_pkg::LinkFree;
          free_d  = free_q + 1'b1;
          head_d  = 1'b0;
          if (rd_data == fca_pkg::LinkEnd || 32'(rd_data) >= NUM_BLOCKS ||
              32'(rd_data) == 32'(cur_q)) begin
            res_status_d = fca_pkg::ST_OK;
            state_d      = fca_pkg::S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rd_data[AW-1:0];
            cur_d   = rd_data[AW-1:0];
          end
        end
      end

      fca_pkg::S_READ_WAIT: begin
        if (rd_data == fca_pkg::LinkFree) begin
          res_status_d = fca_pkg::ST_INVALID;
        end else if (rd_data == fca_pkg::LinkEnd) begin
          res_end_d = 1'b1;
        end else begin
          res_addr_d = rd_data[9:0];
        end
        state_d = fca_pkg::S_DONE;
      end

      fca_pkg::S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d           = 1'b1;
          out_data_d.status     = res_status_q;
          out_data_d.block_addr = res_addr_q;
          out_data_d.is_end     = res_end_q;
          out_data_d.free_count = free_ext[10:0];
          state_d               = fca_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = fca_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fca_pkg::S_CLEAR;
      clr_q       <= '0;
      clr_resp_q  <= 1'b0;
      pend_q      <= 1'b0;
      head_q      <= 1'b0;
      taken_q     <= '0;
      count_q     <= '0;
      free_q      <= FW'(NUM_BLOCKS);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_resp_q  <= clr_resp_d;
      pend_q      <= pend_d;
      head_q      <= head_d;
      taken_q     <= taken_d;
      count_q     <= count_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    first_q      <= first_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_end_q    <= res_end_d;
    out_data_q   <= out_data_d;
  end

endmodule

`default_nettype wire

/* src/fca_ram.sv */
// ----------------------------------------------------------------------------
// fca_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire
